// File: rtl/core/per_cpu_page_free_list_allocator_core_defines.svh
// Assertion macros used by the checker file of the page allocator core.
// Depends on nothing; take it in by include before the first use.
`ifndef PER_CPU_PAGE_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define PER_CPU_PAGE_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, off while in reset
`define PPFL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define PPFL_ASSERT_NEXT(lbl, clk, ante, cons, rstn, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define PPFL_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ppfl_pkg.sv
// Shared types and codes of the per-CPU page allocator core.
// No dependencies; imported by the top level, the checker and the testbench.
`timescale 1ns / 1ps

package ppfl_pkg;

  localparam int ADDR_W    = 32;
  localparam int CPU_ID_W  = 3;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic CMD_FREE  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;

  localparam logic [ADDR_W-1:0] LOWER_RESET = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] UPPER_RESET = 32'h8800_0000;

  typedef struct packed {
    logic                cmd;
    logic [CPU_ID_W-1:0] cpu_id;
    logic [ADDR_W-1:0]   page_address;
  } in_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   result_address;
    logic [STATUS_W-1:0] status;
  } out_rsp_t;

endpackage

// File: rtl/core/ppfl_link_mem.sv
// Next-page link memory, one write port and one registered read port.
// Entries hold no reset value; depends on nothing.
`timescale 1ns / 1ps

module ppfl_link_mem #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [AW-1:0] wd,
  input  logic          re,
  input  logic [AW-1:0] ra,
  output logic [AW-1:0] rd
);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule

// File: rtl/core/ppfl_list_tbl.sv
// Per-CPU list table: head index, list count and a nonempty flag per CPU.
// One read index and one write port; an entry without its flag reads empty.
`timescale 1ns / 1ps

module ppfl_list_tbl #(
  parameter int CPU_COUNT = 8,
  parameter int CW        = 3,
  parameter int IW        = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [CW-1:0]        ri,
  output logic [IW-1:0]        rd_head,
  output logic [31:0]          rd_cnt,
  output logic [CPU_COUNT-1:0] nz,
  input  logic                 we,
  input  logic [CW-1:0]        wi,
  input  logic [IW-1:0]        wh,
  input  logic [31:0]          wc
);

  logic [IW-1:0]        head_r [CPU_COUNT];
  logic [31:0]          cnt_r  [CPU_COUNT];
  logic [CPU_COUNT-1:0] nz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nz_r <= '0;
    end else if (we) begin
      nz_r[wi] <= (wc != 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      head_r[wi] <= wh;
      cnt_r[wi]  <= wc;
    end
  end

  assign rd_head = nz_r[ri] ? head_r[ri] : '0;
  assign rd_cnt  = nz_r[ri] ? cnt_r[ri]  : 32'd0;
  assign nz      = nz_r;

endmodule

// File: rtl/core/per_cpu_page_free_list_allocator_core.sv
// Top level of the per-CPU page allocator: control sequencer and config registers.
// Uses ppfl_pkg, ppfl_list_tbl and ppfl_link_mem.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_data (cmd, cpu_id, page_address)
//   out     | output    | out_valid/out_stall| out_data (result_address, status)
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A free, a bad free, an out-of-memory alloc and an alloc from the own list pass through
// accept, then execute on the link word read at accept (registered memory read).
// A steal from another list passes through accept, execute, setup, a walk unless the
// victim list has length 1 (one link read per cycle along it), and finish.
// Reset clears the list flags and the output register at once; the link memory has no
// clearing pass. A stalled result holds in the output register while the next request
// is accepted; execution waits for the register to free up.
`timescale 1ns / 1ps

module per_cpu_page_free_list_allocator_core
  import ppfl_pkg::*;
#(
  parameter int CPU_COUNT  = 8,
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_SHIFT = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_req_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_rsp_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int IW = $clog2(MAX_PAGES);
  localparam int PN = ADDR_W - PAGE_SHIFT;

  typedef enum logic [2:0] {S_IDLE, S_EXEC, S_SETUP, S_WALK, S_FIN} state_t;

  function automatic logic [CW-1:0] cpu_wrap(input logic [CPU_ID_W-1:0] id);
    logic [4:0] r;
    r = 5'(id);
    for (int i = 0; i < 8; i++) begin
      if (r >= 5'(CPU_COUNT)) begin
        r = r - 5'(CPU_COUNT);
      end
    end
    return r[CW-1:0];
  endfunction

  logic [ADDR_W-1:0] lower_r, upper_r;

  state_t        state_r, state_nxt;
  logic          cmd_r, cmd_nxt;
  logic [CW-1:0] cpu_r, cpu_nxt;
  logic          bad_r, bad_nxt;
  logic [PN-1:0] diff_r, diff_nxt;
  logic [CW-1:0] victim_r, victim_nxt;
  logic [IW-1:0] got_r, got_nxt;
  logic [IW-1:0] first_r, first_nxt;
  logic [31:0]   n_r, n_nxt;
  logic [31:0]   k_r, k_nxt;
  logic [31:0]   steps_r, steps_nxt;
  logic          first_step_r, first_step_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_rsp_t      out_data_r, out_data_nxt;

  logic [CW-1:0]        tbl_ri, tbl_wi;
  logic [IW-1:0]        tbl_rd_head, tbl_wh;
  logic [31:0]          tbl_rd_cnt, tbl_wc;
  logic [CPU_COUNT-1:0] tbl_nz;
  logic                 tbl_we;

  logic          lk_we, lk_re;
  logic [IW-1:0] lk_wa, lk_wd, lk_ra, lk_rd;

  logic [CW-1:0]        cpu_in;
  logic [CPU_COUNT-1:0] avail;
  logic [CW-1:0]        victim_sel;
  logic                 victim_found;
  logic                 can_emit, emit, emit_zero;
  logic [STATUS_W-1:0]  emit_st;
  logic [IW-1:0]        emit_idx;
  logic [ADDR_W-1:0]    emit_page, emit_addr;
  logic [ADDR_W-1:0]    diff_ext;
  logic                 free_ok;
  logic [31:0]          k_setup;

  ppfl_list_tbl #(
    .CPU_COUNT(CPU_COUNT),
    .CW       (CW),
    .IW       (IW)
  ) u_tbl (
    .clk    (clk),
    .rst_n  (rst_n),
    .ri     (tbl_ri),
    .rd_head(tbl_rd_head),
    .rd_cnt (tbl_rd_cnt),
    .nz     (tbl_nz),
    .we     (tbl_we),
    .wi     (tbl_wi),
    .wh     (tbl_wh),
    .wc     (tbl_wc)
  );

  ppfl_link_mem #(
    .DEPTH(MAX_PAGES),
    .AW   (IW)
  ) u_link (
    .clk(clk),
    .we (lk_we),
    .wa (lk_wa),
    .wd (lk_wd),
    .re (lk_re),
    .ra (lk_ra),
    .rd (lk_rd)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= LOWER_RESET;
      upper_r <= UPPER_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LOWER: lower_r <= cfg_data;
        CFG_UPPER: upper_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cpu_in = cpu_wrap(in_data.cpu_id);

  always_comb begin
    victim_sel   = '0;
    victim_found = 1'b0;
    for (int i = 0; i < CPU_COUNT; i++) begin
      avail[i] = tbl_nz[i] && (CW'(i) != cpu_r);
    end
    for (int i = CPU_COUNT - 1; i >= 0; i--) begin
      if (avail[i]) begin
        victim_sel   = CW'(i);
        victim_found = 1'b1;
      end
    end
  end

  assign diff_ext  = ADDR_W'(diff_r);
  assign free_ok   = !bad_r && (diff_ext < ADDR_W'(MAX_PAGES));
  assign k_setup   = (tbl_rd_cnt == 32'd1) ? 32'd1 : (tbl_rd_cnt >> 1);
  assign can_emit  = !out_valid_r || !out_stall;
  assign emit_page = ADDR_W'(emit_idx) + (lower_r >> PAGE_SHIFT);
  assign emit_addr = emit_zero ? '0 : (emit_page << PAGE_SHIFT);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    cpu_nxt        = cpu_r;
    bad_nxt        = bad_r;
    diff_nxt       = diff_r;
    victim_nxt     = victim_r;
    got_nxt        = got_r;
    first_nxt      = first_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    steps_nxt      = steps_r;
    first_step_nxt = first_step_r;
    tbl_ri         = cpu_r;
    tbl_we         = 1'b0;
    tbl_wi         = cpu_r;
    tbl_wh         = '0;
    tbl_wc         = 32'd0;
    lk_re          = 1'b0;
    lk_ra          = tbl_rd_head;
    lk_we          = 1'b0;
    lk_wa          = diff_ext[IW-1:0];
    lk_wd          = tbl_rd_head;
    emit           = 1'b0;
    emit_zero      = 1'b1;
    emit_st        = ST_DONE;
    emit_idx       = got_r;

    unique case (state_r)
      S_IDLE: begin
        tbl_ri = cpu_in;
        if (in_valid) begin
          cmd_nxt   = in_data.cmd;
          cpu_nxt   = cpu_in;
          bad_nxt   = (in_data.page_address[PAGE_SHIFT-1:0] != '0)
                      || (in_data.page_address < lower_r)
                      || (in_data.page_address >= upper_r);
          diff_nxt  = in_data.page_address[ADDR_W-1:PAGE_SHIFT]
                      - lower_r[ADDR_W-1:PAGE_SHIFT];
          lk_re     = (in_data.cmd == CMD_ALLOC);
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_emit) begin
          priority if (cmd_r == CMD_FREE) begin
            emit      = 1'b1;
            emit_st   = free_ok ? ST_DONE : ST_BADFREE;
            lk_we     = free_ok;
            tbl_we    = free_ok;
            tbl_wh    = diff_ext[IW-1:0];
            tbl_wc    = (tbl_rd_cnt == '1) ? tbl_rd_cnt : tbl_rd_cnt + 32'd1;
            state_nxt = S_IDLE;
          end else if (tbl_nz[cpu_r]) begin
            emit      = 1'b1;
            emit_zero = 1'b0;
            emit_idx  = tbl_rd_head;
            tbl_we    = 1'b1;
            tbl_wh    = lk_rd;
            tbl_wc    = tbl_rd_cnt - 32'd1;
            state_nxt = S_IDLE;
          end else if (!victim_found) begin
            emit      = 1'b1;
            emit_st   = ST_OOM;
            state_nxt = S_IDLE;
          end else begin
            victim_nxt = victim_sel;
            state_nxt  = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        tbl_ri  = victim_r;
        n_nxt   = tbl_rd_cnt;
        got_nxt = tbl_rd_head;
        k_nxt   = k_setup;
        if (tbl_rd_cnt == 32'd1) begin
          tbl_we    = 1'b1;
          tbl_wi    = victim_r;
          first_nxt = '0;
          state_nxt = S_FIN;
        end else begin
          lk_re          = 1'b1;
          lk_ra          = tbl_rd_head;
          steps_nxt      = k_setup;
          first_step_nxt = 1'b1;
          state_nxt      = S_WALK;
        end
      end
      S_WALK: begin
        first_step_nxt = 1'b0;
        if (first_step_r) begin
          first_nxt = lk_rd;
        end
        if (steps_r == 32'd1) begin
          tbl_we    = 1'b1;
          tbl_wi    = victim_r;
          tbl_wh    = lk_rd;
          tbl_wc    = n_r - k_r;
          state_nxt = S_FIN;
        end else begin
          lk_re     = 1'b1;
          lk_ra     = lk_rd;
          steps_nxt = steps_r - 32'd1;
        end
      end
      S_FIN: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_zero = 1'b0;
          tbl_we    = 1'b1;
          tbl_wh    = (k_r > 32'd1) ? first_r : '0;
          tbl_wc    = k_r - 32'd1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.result_address = emit_addr;
      out_data_nxt.status         = emit_st;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      first_step_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      first_step_r <= first_step_nxt;
    end
    cmd_r      <= cmd_nxt;
    cpu_r      <= cpu_nxt;
    bad_r      <= bad_nxt;
    diff_r     <= diff_nxt;
    victim_r   <= victim_nxt;
    got_r      <= got_nxt;
    first_r    <= first_nxt;
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    steps_r    <= steps_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/core/ppfl_checker.sv
// Port-level checks on the result channel of the page allocator core.
// Uses ppfl_pkg and the shared assertion macros; bound to the top level below.
`timescale 1ns / 1ps
`include "per_cpu_page_free_list_allocator_core_defines.svh"

module ppfl_checker
  import ppfl_pkg::*;
#(
  parameter int PAGE_SHIFT = 12
) (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input out_rsp_t out_data
);

  `PPFL_ASSERT_NEXT(a_out_hold, clk, out_valid && out_stall, out_valid && $stable(out_data), rst_n, "stalled result changed")
  `PPFL_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, out_data.status == ST_DONE || out_data.status == ST_OOM || out_data.status == ST_BADFREE, "illegal status code")
  `PPFL_ASSERT_IMP(a_fail_zero, clk, rst_n, out_valid && out_data.status != ST_DONE, out_data.result_address == '0, "failed request returned an address")
  `PPFL_ASSERT_IMP(a_page_aligned, clk, rst_n, out_valid, out_data.result_address[PAGE_SHIFT-1:0] == '0, "result address not page aligned")
  `PPFL_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid, "result valid after reset")

endmodule

bind per_cpu_page_free_list_allocator_core ppfl_checker #(
  .PAGE_SHIFT(PAGE_SHIFT)
) u_ppfl_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// File: tb/sv/tb.sv
// Self-checking testbench for per_cpu_page_free_list_allocator_core: a tracker class
// predicts the answer to every request and checks them in order. Depends on ppfl_pkg.
`timescale 1ns / 1ps

module tb
  import ppfl_pkg::*;
();

  localparam int CPUS         = 8;
  localparam int PAGES        = 32768;
  localparam int PSHIFT       = 12;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 220;

  class page_list_tracker;
    bit [ADDR_W-1:0] lower_q;
    bit [ADDR_W-1:0] upper_q;
    int unsigned     head [CPUS];
    int unsigned     len [CPUS];
    int unsigned     link [PAGES];
    out_rsp_t        due_replies [$];
    bit [ADDR_W-1:0] held [$];
    int              mismatches;

    function new();
      lower_q    = LOWER_RESET;
      upper_q    = UPPER_RESET;
      mismatches = 0;
      foreach (head[i]) begin
        head[i] = 0;
        len[i]  = 0;
      end
    endfunction

    function bit [ADDR_W-1:0] page_addr(int unsigned idx);
      bit [ADDR_W-1:0] pg;
      pg = idx + (lower_q >> PSHIFT);
      return pg << PSHIFT;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
      if (idx == CFG_LOWER) lower_q = val;
      else if (idx == CFG_UPPER) upper_q = val;
    endfunction

    function void take_request(in_req_t r);
      out_rsp_t        want;
      int unsigned     c, idx, n, k, node, got;
      bit [ADDR_W-1:0] a;
      bit              found;
      want  = '0;
      c     = r.cpu_id % CPUS;
      a     = r.page_address;
      found = 0;
      if (r.cmd == CMD_FREE) begin
        want.status = ST_BADFREE;
        if (a[PSHIFT-1:0] == '0 && a >= lower_q && a < upper_q) begin
          idx = (a >> PSHIFT) - (lower_q >> PSHIFT);
          if (idx < PAGES) begin
            link[idx] = head[c];
            head[c]   = idx;
            if (len[c] != 32'hFFFF_FFFF) len[c]++;
            want.status = ST_DONE;
          end
        end
      end else if (len[c] != 0) begin
        got     = head[c];
        head[c] = link[got];
        len[c]--;
        want.result_address = page_addr(got);
        want.status         = ST_DONE;
      end else begin
        for (int v = 0; v < CPUS; v++) begin
          if (!found && v != c && len[v] != 0) begin
            n    = len[v];
            k    = (n == 1) ? 1 : n / 2;
            got  = head[v];
            node = got;
            for (int i = 0; i < k; i++) node = link[node];
            head[v] = (n - k != 0) ? node : 0;
            len[v]  = n - k;
            head[c] = (k > 1) ? link[got] : 0;
            len[c]  = k - 1;
            want.result_address = page_addr(got);
            want.status         = ST_DONE;
            found = 1;
          end
        end
        if (!found) want.status = ST_OOM;
      end
      if (r.cmd == CMD_ALLOC && want.status == ST_DONE) held.push_back(want.result_address);
      due_replies.push_back(want);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_reply(out_rsp_t got);
      out_rsp_t want;
      if (due_replies.size() == 0) begin
        report($sformatf("unexpected reply: addr %h status %0d",
                         got.result_address, got.status));
        return;
      end
      want = due_replies.pop_front();
      if (got.result_address !== want.result_address || got.status !== want.status)
        report($sformatf("reply mismatch: expected addr %h status %0d, got addr %h status %0d",
                         want.result_address, want.status,
                         got.result_address, got.status));
    endfunction

    function int pending();
      return due_replies.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_req_t              in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_rsp_t             out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  page_list_tracker sb;
  bit               calm;

  bit [ADDR_W-1:0] lo_set [PHASES] = '{32'h8000_0000, 32'h0000_0000, 32'hFFFF_0000,
                                       32'h4000_0000, 32'h9000_0000, 32'h1234_5000,
                                       32'h0000_0801};
  bit [ADDR_W-1:0] hi_set [PHASES] = '{32'h8800_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                       32'h4000_0000, 32'h1000_0000, 32'h1238_5000,
                                       32'h0010_0000};
  int unsigned     free_pct [PHASES] = '{55, 50, 60, 50, 40, 65, 50};

  per_cpu_page_free_list_allocator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 31);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_reply(out_data);
      if (in_valid && !in_stall) sb.take_request(in_data);
      if (cfg_valid && cfg_ready) sb.note_config(cfg_index, cfg_data);
    end
  end

  function automatic in_req_t mk(logic cmd, int unsigned cpu, bit [ADDR_W-1:0] addr);
    in_req_t r;
    r.cmd          = cmd;
    r.cpu_id       = CPU_ID_W'(cpu);
    r.page_address = addr;
    return r;
  endfunction

  function automatic in_req_t random_request(int unsigned pct);
    in_req_t         r;
    int unsigned     pick;
    int unsigned     slot;
    bit [ADDR_W-1:0] pg;
    r.cpu_id       = CPU_ID_W'($urandom_range(CPUS - 1));
    r.page_address = $urandom;
    r.cmd          = CMD_ALLOC;
    pg             = sb.lower_q >> PSHIFT;
    if ($urandom_range(99) >= pct) return r;
    r.cmd = CMD_FREE;
    pick  = $urandom_range(99);
    if (pick < 60 && sb.held.size() != 0) begin
      slot           = $urandom_range(sb.held.size() - 1);
      r.page_address = sb.held[slot];
      sb.held.delete(slot);
    end else if (pick < 82) begin
      r.page_address = (pg + $urandom_range(255)) << PSHIFT;
    end else if (pick < 92) begin
      case ($urandom_range(4))
        0:       r.page_address = sb.upper_q - 32'h1000;
        1:       r.page_address = sb.upper_q;
        2:       r.page_address = sb.lower_q - 32'h1000;
        3:       r.page_address = (pg + PAGES) << PSHIFT;
        default: r.page_address = (pg + PAGES - 1) << PSHIFT;
      endcase
    end else if (pick < 96) begin
      r.page_address = ((pg + $urandom_range(255)) << PSHIFT) + $urandom_range(1, 4095);
    end
    return r;
  endfunction

  task automatic send_request(in_req_t r);
    if (!calm) begin
      while ($urandom_range(99) < 31) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // hold the sender until every request is answered, then let the core go quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    sb        = new;
    calm      = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_LOWER;
    cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(mk(CMD_ALLOC, 0, 32'h0000_0000));
    send_request(mk(CMD_FREE,  0, 32'h8000_0000));
    send_request(mk(CMD_FREE,  0, 32'h87FF_F000));
    send_request(mk(CMD_FREE,  0, 32'h8800_0000));
    send_request(mk(CMD_FREE,  0, 32'h7FFF_F000));
    send_request(mk(CMD_FREE,  0, 32'h8000_0001));
    send_request(mk(CMD_FREE,  1, 32'hFFFF_FFFF));
    send_request(mk(CMD_FREE,  1, 32'h0000_0000));
    send_request(mk(CMD_FREE,  7, 32'h8000_5000));
    send_request(mk(CMD_FREE,  3, 32'h8001_0000));
    send_request(mk(CMD_FREE,  3, 32'h8001_1000));
    send_request(mk(CMD_FREE,  3, 32'h8001_2000));
    send_request(mk(CMD_FREE,  3, 32'h8001_1000));
    send_request(mk(CMD_ALLOC, 0, 32'hFFFF_FFFF));
    send_request(mk(CMD_ALLOC, 0, 32'h0000_0000));
    send_request(mk(CMD_ALLOC, 0, 32'h1234_5678));
    send_request(mk(CMD_ALLOC, 0, 32'h0000_0000));
    send_request(mk(CMD_ALLOC, 4, 32'h0000_0000));
    send_request(mk(CMD_ALLOC, 5, 32'h0000_0000));
    send_request(mk(CMD_ALLOC, 6, 32'h0000_0000));
    send_request(mk(CMD_ALLOC, 2, 32'h0000_0000));
    send_request(mk(CMD_ALLOC, 7, 32'hFFFF_FFFF));

    for (int p = 0; p < PHASES; p++) begin
      settle();
      calm = (p == 2);
      cfg_write(CFG_LOWER, lo_set[p]);
      cfg_write(CFG_UPPER, hi_set[p]);
      repeat (PHASE_ITEMS) send_request(random_request(free_pct[p]));
    end
    settle();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/ppfl_pkg.sv
rtl/core/ppfl_link_mem.sv
rtl/core/ppfl_list_tbl.sv
rtl/core/per_cpu_page_free_list_allocator_core.sv
rtl/core/ppfl_checker.sv
tb/sv/tb.sv
